FILE: hw/rtl/hv_run_length_opening_core_assert.svh
// Assertion macros shared by the run-length opening checker.
`ifndef HV_RUN_LENGTH_OPENING_CORE_ASSERT_SVH
`define HV_RUN_LENGTH_OPENING_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define HVRL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define HVRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/hvrl_pkg.sv
// Package with the types and constants of the run-length opening block.
package hvrl_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int CFG_W          = 9;
    localparam int RUN_W          = 10;
    localparam int COORD_W        = 8;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam logic [CFG_W-1:0] CFG_RESET_SIZE = 9'd256;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } t_action;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTER,
        ST_CWAIT,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic                flag_bit;
    } t_in_item;

    typedef struct packed {
        logic signed [RUN_W-1:0] run_value;
        logic                    range_error;
    } t_out_item;

endpackage

FILE: hw/rtl/hvrl_mem.sv
// Single-port flag memory with a registered read port.
module hvrl_mem
    import hvrl_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/hvrl_step.sv
// Shared step unit that moves a scan position by one and flags the edge of the mask.
module hvrl_step
    import hvrl_pkg::*;
#(
    parameter int PW = 8
) (
    input  t_dir          i_dir,
    input  logic [PW-1:0] i_pos,
    input  logic [PW:0]   i_lim_w,
    input  logic [PW:0]   i_lim_h,
    output logic [PW-1:0] o_next,
    output logic          o_edge
);

    logic          dec;
    logic [PW:0]   lim;
    logic [PW:0]   pos_inc;

    always_comb begin
        dec     = (i_dir == DIR_LEFT) || (i_dir == DIR_UP);
        lim     = ((i_dir == DIR_LEFT) || (i_dir == DIR_RIGHT)) ? i_lim_w : i_lim_h;
        pos_inc = {1'b0, i_pos} + {{PW{1'b0}}, 1'b1};
        if (dec) begin
            o_next = i_pos - {{(PW-1){1'b0}}, 1'b1};
            o_edge = (i_pos == '0);
        end else begin
            o_next = pos_inc[PW-1:0];
            o_edge = (pos_inc >= lim);
        end
    end

endmodule

FILE: hw/rtl/hvrl_ctrl.sv
// Sequencer that clears the mask, takes items and scans the four runs of a pixel.
module hvrl_ctrl
    import hvrl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    output logic                                                  o_busy,
    input  t_in_item                                              i_item,
    input  logic [CFG_W-1:0]                                      i_cfg_w,
    input  logic [CFG_W-1:0]                                      i_cfg_h,
    output logic                                                  o_mem_we,
    output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)-1:0]       o_mem_addr,
    output logic                                                  o_mem_wdata,
    input  logic                                                  i_mem_rdata,
    output t_dir                                                  o_step_dir,
    output logic [(($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0]   o_step_pos,
    output logic [(($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT)):0]     o_lim_w,
    output logic [(($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT)):0]     o_lim_h,
    input  logic [(($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                   $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT))-1:0]   i_step_next,
    input  logic                                                  i_step_edge,
    output logic                                                  o_valid,
    output t_out_item                                             o_result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = (CW > RW) ? CW : RW;
    localparam int LW = PW + 1;
    localparam int AW = CW + RW;

    t_state              r_state, n_state;
    t_dir                r_dir, n_dir;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_iss, n_iss;
    logic                r_pend, n_pend;
    logic                r_valid, n_valid;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [PW-1:0]       r_pos, n_pos;
    logic [RUN_W-1:0]    r_hl, n_hl;
    logic [RUN_W-1:0]    r_vl, n_vl;
    t_out_item           r_result, n_result;

    logic [31:0]         w32, h32, col32, row32;
    logic [CW:0]         eff_w;
    logic [RW:0]         eff_h;
    logic                in_range;
    logic                horiz;
    logic                done_now;
    logic                inc;
    logic [RUN_W-1:0]    hl_f, vl_f, run;
    logic [PW-1:0]       col_p, row_p;
    t_dir                next_dir;
    logic [AW-1:0]       scan_addr;

    always_comb begin
        w32   = (32'(i_cfg_w) > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : 32'(i_cfg_w);
        h32   = (32'(i_cfg_h) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(i_cfg_h);
        eff_w = w32[CW:0];
        eff_h = h32[RW:0];
        col32 = 32'(i_item.col);
        row32 = 32'(i_item.row);
        in_range = (col32 < 32'(eff_w)) && (row32 < 32'(eff_h));

        col_p = PW'(r_col);
        row_p = PW'(r_row);
        horiz = (r_dir == DIR_LEFT) || (r_dir == DIR_RIGHT);
        done_now = !r_iss || (r_pend && !i_mem_rdata);
        inc      = r_pend && i_mem_rdata;
        hl_f = r_hl + RUN_W'(inc && horiz);
        vl_f = r_vl + RUN_W'(inc && !horiz);
        run  = (hl_f >= vl_f) ? hl_f : ((~vl_f) + RUN_W'(1));

        scan_addr = horiz ? {r_row, r_pos[CW-1:0]} : {r_pos[RW-1:0], r_col};

        unique case (r_dir)
            DIR_LEFT:  next_dir = DIR_RIGHT;
            DIR_RIGHT: next_dir = DIR_UP;
            DIR_UP:    next_dir = DIR_DOWN;
            DIR_DOWN:  next_dir = DIR_DOWN;
        endcase

        o_step_dir = r_dir;
        o_step_pos = r_pos;
        if (r_state == ST_CWAIT) begin
            o_step_dir = DIR_LEFT;
            o_step_pos = col_p;
        end else if ((r_state == ST_SCAN) && done_now) begin
            o_step_dir = next_dir;
            o_step_pos = (next_dir == DIR_RIGHT) ? col_p : row_p;
        end
        o_lim_w = LW'(eff_w);
        o_lim_h = LW'(eff_h);
    end

    always_comb begin
        n_state  = r_state;
        n_dir    = r_dir;
        n_clr    = r_clr;
        n_iss    = r_iss;
        n_pend   = r_pend;
        n_valid  = 1'b0;
        n_col    = r_col;
        n_row    = r_row;
        n_pos    = r_pos;
        n_hl     = r_hl;
        n_vl     = r_vl;
        n_result = r_result;
        o_mem_we    = 1'b0;
        o_mem_addr  = scan_addr;
        o_mem_wdata = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we   = 1'b1;
                o_mem_addr = r_clr;
                n_clr      = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_item.action == ACT_WRITE) begin
                        o_mem_we    = in_range;
                        o_mem_addr  = {row32[RW-1:0], col32[CW-1:0]};
                        o_mem_wdata = i_item.flag_bit;
                    end else if (!in_range) begin
                        n_valid  = 1'b1;
                        n_result = '{run_value: '0, range_error: 1'b1};
                    end else begin
                        n_col   = col32[CW-1:0];
                        n_row   = row32[RW-1:0];
                        n_state = ST_CENTER;
                    end
                end
            end
            ST_CENTER: begin
                o_mem_addr = {r_row, r_col};
                n_state    = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (!i_mem_rdata) begin
                    n_valid  = 1'b1;
                    n_result = '{run_value: '0, range_error: 1'b0};
                    n_state  = ST_IDLE;
                end else begin
                    n_hl    = RUN_W'(1);
                    n_vl    = RUN_W'(1);
                    n_dir   = DIR_LEFT;
                    n_pos   = i_step_next;
                    n_iss   = !i_step_edge;
                    n_pend  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_hl = hl_f;
                n_vl = vl_f;
                if (done_now) begin
                    if (r_dir == DIR_DOWN) begin
                        n_valid  = 1'b1;
                        n_result = '{run_value: $signed(run), range_error: 1'b0};
                        n_state  = ST_IDLE;
                    end else begin
                        n_dir  = next_dir;
                        n_pos  = i_step_next;
                        n_iss  = !i_step_edge;
                        n_pend = 1'b0;
                    end
                end else begin
                    n_pend = 1'b1;
                    n_iss  = !i_step_edge;
                    n_pos  = i_step_next;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_dir   <= DIR_LEFT;
            r_clr   <= '0;
            r_iss   <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_clr   <= n_clr;
            r_iss   <= n_iss;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_row    <= n_row;
        r_pos    <= n_pos;
        r_hl     <= n_hl;
        r_vl     <= n_vl;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: hw/rtl/hv_run_length_opening_core.sv
// Top level of the run-length opening block with its register port.
// A write item completes at the edge that accepts it and gives no result.
// An out-of-range read gives its result in the cycle after acceptance, a clear pixel after ST_CENTER and ST_CWAIT.
// A set pixel with runs h and v gives its result after the scans left, right, up and down.
// Reset starts a clearing pass over all 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) mask addresses.
// During the clearing pass busy is high; results cannot be stalled by the receiver.
module hv_run_length_opening_core
    import hvrl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_valid,
    output t_out_item         o_result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = (CW > RW) ? CW : RW;
    localparam int AW = CW + RW;

    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    t_reg_idx         reg_idx;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic             mem_wdata;
    logic             mem_rdata;
    t_dir             step_dir;
    logic [PW-1:0]    step_pos;
    logic [PW-1:0]    step_next;
    logic             step_edge;
    logic [PW:0]      lim_w;
    logic [PW:0]      lim_h;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_RESET_SIZE;
            r_cfg_h <= CFG_RESET_SIZE;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_WIDTH:  r_cfg_w <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_cfg_h <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DW'(r_cfg_w);
            REG_HEIGHT: prdata = APB_DW'(r_cfg_h);
        endcase
    end

    hvrl_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (i_item),
        .i_cfg_w     (r_cfg_w),
        .i_cfg_h     (r_cfg_h),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .o_step_dir  (step_dir),
        .o_step_pos  (step_pos),
        .o_lim_w     (lim_w),
        .o_lim_h     (lim_h),
        .i_step_next (step_next),
        .i_step_edge (step_edge),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    hvrl_step #(
        .PW (PW)
    ) u_step (
        .i_dir   (step_dir),
        .i_pos   (step_pos),
        .i_lim_w (lim_w),
        .i_lim_h (lim_h),
        .o_next  (step_next),
        .o_edge  (step_edge)
    );

    hvrl_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: hw/rtl/hvrl_checker.sv
// Port-level checker for the run-length opening block and its bind statement.
`include "hv_run_length_opening_core_assert.svh"

module hvrl_checker
    import hvrl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_valid,
    input t_out_item o_result
);

    `HVRL_ASSERT_IMPL(a_err_zero, o_valid && o_result.range_error, o_result.run_value == '0, "range error with a nonzero run value")
    `HVRL_ASSERT_IMPL(a_res_idle, o_valid, !busy, "result shown while the block is busy")
    `HVRL_ASSERT_NEXT(a_wr_silent, start && !busy && (i_item.action == ACT_WRITE), !o_valid, "a write item gave a result")
    `HVRL_ASSERT_NEXT(a_rd_moves, start && !busy && (i_item.action == ACT_READ), busy || o_valid, "a read item was dropped")

endmodule

bind hv_run_length_opening_core hvrl_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);
